/* rtl/core/bole_pkg.sv */
// Shared types and constants for the bounded ordered list engine.
// Used by bole_front, bole_back and the top level; depends on nothing.
package bole_pkg;

    // List capacity and derived widths.
    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int WORD_W   = 32;
    localparam int ACT_W    = 4;
    localparam int ST_W     = 3;
    localparam int CMP_W    = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

    // Command codes.
    localparam logic [ACT_W-1:0] ACT_INS_HEAD   = 4'd0;
    localparam logic [ACT_W-1:0] ACT_INS_TAIL   = 4'd1;
    localparam logic [ACT_W-1:0] ACT_INS_POS    = 4'd2;
    localparam logic [ACT_W-1:0] ACT_FIND       = 4'd3;
    localparam logic [ACT_W-1:0] ACT_FIND_ALL   = 4'd4;
    localparam logic [ACT_W-1:0] ACT_INS_AFTER  = 4'd5;
    localparam logic [ACT_W-1:0] ACT_INS_AFTALL = 4'd6;
    localparam logic [ACT_W-1:0] ACT_DEL_HEAD   = 4'd7;
    localparam logic [ACT_W-1:0] ACT_DEL_TAIL   = 4'd8;
    localparam logic [ACT_W-1:0] ACT_DEL_POS    = 4'd9;
    localparam logic [ACT_W-1:0] ACT_DEL_KEY    = 4'd10;
    localparam logic [ACT_W-1:0] ACT_DEL_ALL    = 4'd11;
    localparam logic [ACT_W-1:0] ACT_READ       = 4'd12;

    // Status codes.
    localparam logic [ST_W-1:0] STAT_OK        = 3'd0;
    localparam logic [ST_W-1:0] STAT_NOT_FOUND = 3'd1;
    localparam logic [ST_W-1:0] STAT_EMPTY     = 3'd2;
    localparam logic [ST_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [ST_W-1:0] STAT_RANGE     = 3'd4;

    // Command class decided by the front end.
    typedef enum logic [1:0] {
        CLS_INSERT,
        CLS_DELETE,
        CLS_SCAN,
        CLS_NOP
    } cls_t;

    // One queued command.
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] key;
        logic [POS_W-1:0]  position;
        cls_t              cls;
    } cmd_t;

endpackage

/* rtl/core/bole_front.sv */
// Front end: accepts command items, classifies them and queues them.
// Depends on bole_pkg.
module bole_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata: value [31:0], key [63:32], position [70:64], zero fill [71]
    input  logic [71:0]           s_tdata,
    // s_tuser: action [3:0]
    input  logic [3:0]            s_tuser,
    output logic                  q_valid,
    input  logic                  q_ready,
    output bole_pkg::cmd_t        q_cmd
);
    import bole_pkg::*;

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    cmd_t       in_cmd;
    logic       push, pop;

    // Classify the incoming command.
    always_comb begin
        in_cmd.action   = s_tuser;
        in_cmd.value    = s_tdata[31:0];
        in_cmd.key      = s_tdata[63:32];
        in_cmd.position = s_tdata[70:64];
        if (s_tuser <= ACT_INS_POS) begin
            in_cmd.cls = CLS_INSERT;
        end else if (s_tuser >= ACT_DEL_HEAD && s_tuser <= ACT_DEL_POS) begin
            in_cmd.cls = CLS_DELETE;
        end else if (s_tuser <= ACT_READ) begin
            in_cmd.cls = CLS_SCAN;
        end else begin
            in_cmd.cls = CLS_NOP;
        end
    end

    assign s_tready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_cmd    = fifo_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    // Queue pointers.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* rtl/core/bole_back.sv */
// Back end: executes queued commands on the list memory and drives results.
// Depends on bole_pkg.
module bole_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  bole_pkg::cmd_t        q_cmd,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: found_position [6:0], element [38:7], length [45:39], zero fill [47:46]
    output logic [47:0]           m_tdata,
    // m_tuser: status [2:0]
    output logic [2:0]            m_tuser,
    output logic                  m_tlast
);
    import bole_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN_RD, ST_SCAN_EX, ST_SCAN_END, ST_SHR_RD, ST_SHR_WR,
        ST_DEL_RD, ST_DEL_GET, ST_SHL_RD, ST_SHL_WR, ST_INS_RD, ST_INS_EX, ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic [ACT_W-1:0]  act_reg, act_next;
    logic [WORD_W-1:0] val_reg, val_next;
    logic [WORD_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  tgt_reg, tgt_next;
    logic [CNT_W-1:0]  f_reg, f_next;
    logic [CNT_W-1:0]  m_reg, m_next;
    logic [CNT_W-1:0]  dst_reg, dst_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  pend_pos_reg, pend_pos_next;
    logic              found_reg, found_next;
    logic              pend_reg, pend_next;
    logic              flag_reg, flag_next;
    logic [ST_W-1:0]   res_st_reg, res_st_next;
    logic [CNT_W-1:0]  res_pos_reg, res_pos_next;
    logic [WORD_W-1:0] res_el_reg, res_el_next;

    // Output register.
    logic              o_valid_reg;
    logic [ST_W-1:0]   o_st_reg;
    logic [POS_W-1:0]  o_pos_reg;
    logic [WORD_W-1:0] o_el_reg;
    logic [POS_W-1:0]  o_len_reg;
    logic              o_last_reg;

    // List memory.
    logic [WORD_W-1:0] mem [CAPACITY];
    logic [WORD_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [WORD_W-1:0] mem_wd;

    // Result load strobe and payload.
    logic              load;
    logic [ST_W-1:0]   ld_st;
    logic [CNT_W-1:0]  ld_pos;
    logic [WORD_W-1:0] ld_el;
    logic              ld_last;

    logic              out_free;
    logic              hit;
    logic [CMP_W-1:0]  n_ext, p_ext, sum_ext;
    logic [CNT_W-1:0]  idx;

    assign out_free = !o_valid_reg || m_tready;
    assign hit      = (rd_data_reg == key_reg);
    assign n_ext    = CMP_W'(cnt_reg);
    assign p_ext    = CMP_W'(q_cmd.position);
    assign sum_ext  = CMP_W'(cnt_reg) + CMP_W'(m_reg);
    assign q_ready  = (state_reg == ST_IDLE);

    // Command sequencer.
    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        val_next      = val_reg;
        key_next      = key_reg;
        i_next        = i_reg;
        tgt_next      = tgt_reg;
        f_next        = f_reg;
        m_next        = m_reg;
        dst_next      = dst_reg;
        cnt_next      = cnt_reg;
        pend_pos_next = pend_pos_reg;
        found_next    = found_reg;
        pend_next     = pend_reg;
        flag_next     = flag_reg;
        res_st_next   = res_st_reg;
        res_pos_next  = res_pos_reg;
        res_el_next   = res_el_reg;
        rd_addr       = i_reg[IDX_W-1:0];
        mem_we        = 1'b0;
        mem_wa        = i_reg[IDX_W-1:0];
        mem_wd        = rd_data_reg;
        load          = 1'b0;
        ld_st         = STAT_OK;
        ld_pos        = '0;
        ld_el         = '0;
        ld_last       = 1'b0;
        idx           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    act_next     = q_cmd.action;
                    val_next     = q_cmd.value;
                    key_next     = q_cmd.key;
                    res_st_next  = STAT_OK;
                    res_pos_next = '0;
                    res_el_next  = '0;
                    state_next   = ST_EMIT;
                    if (q_cmd.cls != CLS_INSERT && q_cmd.cls != CLS_NOP && cnt_reg == '0) begin
                        res_st_next = STAT_EMPTY;
                    end else begin
                        unique case (q_cmd.cls)
                            CLS_NOP: begin
                                res_st_next = STAT_OK;
                            end
                            CLS_INSERT: begin
                                if (q_cmd.action == ACT_INS_HEAD) begin
                                    idx = '0;
                                end else if (q_cmd.action == ACT_INS_TAIL) begin
                                    idx = cnt_reg;
                                end else begin
                                    idx = CNT_W'(p_ext - CMP_W'(1));
                                end
                                if (cnt_reg == CNT_W'(CAPACITY)) begin
                                    res_st_next = STAT_FULL;
                                end else if (q_cmd.action == ACT_INS_POS &&
                                             (p_ext == '0 || p_ext > n_ext + CMP_W'(1))) begin
                                    res_st_next = STAT_RANGE;
                                end else begin
                                    tgt_next     = idx;
                                    i_next       = cnt_reg;
                                    res_pos_next = idx + CNT_W'(1);
                                    res_el_next  = q_cmd.value;
                                    state_next   = ST_SHR_RD;
                                end
                            end
                            CLS_DELETE: begin
                                if (q_cmd.action == ACT_DEL_HEAD) begin
                                    idx = '0;
                                end else if (q_cmd.action == ACT_DEL_TAIL) begin
                                    idx = cnt_reg - CNT_W'(1);
                                end else begin
                                    idx = CNT_W'(p_ext - CMP_W'(1));
                                end
                                if (q_cmd.action == ACT_DEL_POS &&
                                    (p_ext == '0 || p_ext > n_ext)) begin
                                    res_st_next = STAT_RANGE;
                                end else begin
                                    i_next       = idx;
                                    res_pos_next = idx + CNT_W'(1);
                                    state_next   = ST_DEL_RD;
                                end
                            end
                            CLS_SCAN: begin
                                if (q_cmd.action == ACT_INS_AFTER &&
                                    cnt_reg == CNT_W'(CAPACITY)) begin
                                    res_st_next = STAT_FULL;
                                end else begin
                                    i_next     = '0;
                                    m_next     = '0;
                                    found_next = 1'b0;
                                    pend_next  = 1'b0;
                                    flag_next  = 1'b0;
                                    state_next = ST_SCAN_RD;
                                end
                            end
                        endcase
                    end
                end
            end

            // Walk the list one entry at a time: ST_SCAN_RD reads it, ST_SCAN_EX examines it.
            ST_SCAN_RD: begin
                state_next = (i_reg == cnt_reg) ? ST_SCAN_END : ST_SCAN_EX;
            end

            ST_SCAN_EX: begin
                priority case (act_reg)
                    ACT_FIND, ACT_INS_AFTER, ACT_DEL_KEY: begin
                        if (hit) begin
                            found_next = 1'b1;
                            f_next     = i_reg;
                            state_next = ST_SCAN_END;
                        end else begin
                            i_next     = i_reg + CNT_W'(1);
                            state_next = ST_SCAN_RD;
                        end
                    end
                    ACT_INS_AFTALL: begin
                        if (hit) begin
                            m_next = m_reg + CNT_W'(1);
                            if (!found_reg) begin
                                f_next = i_reg;
                            end
                            found_next = 1'b1;
                        end
                        i_next     = i_reg + CNT_W'(1);
                        state_next = ST_SCAN_RD;
                    end
                    ACT_DEL_ALL: begin
                        // In-place compaction of the entries that stay.
                        if (hit) begin
                            if (!found_reg) begin
                                f_next = i_reg;
                            end
                            found_next = 1'b1;
                        end else begin
                            mem_we = 1'b1;
                            mem_wa = m_reg[IDX_W-1:0];
                            m_next = m_reg + CNT_W'(1);
                        end
                        i_next     = i_reg + CNT_W'(1);
                        state_next = ST_SCAN_RD;
                    end
                    ACT_FIND_ALL: begin
                        // A match is held back until the next one shows it is not the last.
                        if (hit && pend_reg) begin
                            if (out_free) begin
                                load          = 1'b1;
                                ld_pos        = pend_pos_reg;
                                ld_el         = key_reg;
                                pend_pos_next = i_reg + CNT_W'(1);
                                i_next        = i_reg + CNT_W'(1);
                                state_next    = ST_SCAN_RD;
                            end
                        end else begin
                            if (hit) begin
                                pend_next     = 1'b1;
                                pend_pos_next = i_reg + CNT_W'(1);
                            end
                            i_next     = i_reg + CNT_W'(1);
                            state_next = ST_SCAN_RD;
                        end
                    end
                    default: begin
                        // Read-out: one result per entry.
                        if (out_free) begin
                            load       = 1'b1;
                            ld_pos     = i_reg + CNT_W'(1);
                            ld_el      = rd_data_reg;
                            ld_last    = (i_reg + CNT_W'(1) == cnt_reg);
                            i_next     = i_reg + CNT_W'(1);
                            state_next = ST_SCAN_RD;
                        end
                    end
                endcase
            end

            ST_SCAN_END: begin
                state_next   = ST_EMIT;
                res_st_next  = STAT_NOT_FOUND;
                res_pos_next = '0;
                res_el_next  = '0;
                priority case (act_reg)
                    ACT_READ: begin
                        state_next = ST_IDLE;
                    end
                    ACT_FIND_ALL: begin
                        if (pend_reg) begin
                            res_st_next  = STAT_OK;
                            res_pos_next = pend_pos_reg;
                            res_el_next  = key_reg;
                        end
                    end
                    ACT_FIND: begin
                        if (found_reg) begin
                            res_st_next  = STAT_OK;
                            res_pos_next = f_reg + CNT_W'(1);
                            res_el_next  = key_reg;
                        end
                    end
                    ACT_INS_AFTER: begin
                        if (found_reg) begin
                            res_st_next  = STAT_OK;
                            res_pos_next = f_reg + CNT_W'(2);
                            res_el_next  = key_reg;
                            tgt_next     = f_reg + CNT_W'(1);
                            i_next       = cnt_reg;
                            state_next   = ST_SHR_RD;
                        end
                    end
                    ACT_DEL_KEY: begin
                        if (found_reg) begin
                            res_st_next  = STAT_OK;
                            res_pos_next = f_reg + CNT_W'(1);
                            res_el_next  = key_reg;
                            i_next       = f_reg;
                            state_next   = ST_SHL_RD;
                        end
                    end
                    ACT_DEL_ALL: begin
                        if (found_reg) begin
                            res_st_next  = STAT_OK;
                            res_pos_next = f_reg + CNT_W'(1);
                            res_el_next  = key_reg;
                            cnt_next     = m_reg;
                        end
                    end
                    default: begin
                        // Insert after every match.
                        if (!found_reg) begin
                            res_st_next = STAT_NOT_FOUND;
                        end else if (sum_ext > CMP_W'(CAPACITY)) begin
                            res_st_next = STAT_FULL;
                        end else begin
                            res_st_next  = STAT_OK;
                            res_pos_next = f_reg + CNT_W'(2);
                            res_el_next  = key_reg;
                            dst_next     = CNT_W'(sum_ext);
                            i_next       = cnt_reg;
                            flag_next    = 1'b0;
                            state_next   = ST_INS_RD;
                        end
                    end
                endcase
            end

            // Open a gap at tgt by moving the tail up one entry.
            ST_SHR_RD: begin
                rd_addr = IDX_W'(i_reg - CNT_W'(1));
                if (i_reg == tgt_reg) begin
                    mem_we     = 1'b1;
                    mem_wa     = tgt_reg[IDX_W-1:0];
                    mem_wd     = val_reg;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_SHR_WR;
                end
            end

            ST_SHR_WR: begin
                mem_we     = 1'b1;
                mem_wa     = i_reg[IDX_W-1:0];
                i_next     = i_reg - CNT_W'(1);
                state_next = ST_SHR_RD;
            end

            ST_DEL_RD: begin
                state_next = ST_DEL_GET;
            end

            ST_DEL_GET: begin
                res_el_next = rd_data_reg;
                state_next  = ST_SHL_RD;
            end

            // Close the gap at i by moving the tail down one entry.
            ST_SHL_RD: begin
                rd_addr = IDX_W'(i_reg + CNT_W'(1));
                if (CMP_W'(i_reg) + CMP_W'(1) >= n_ext) begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_SHL_WR;
                end
            end

            ST_SHL_WR: begin
                mem_we     = 1'b1;
                mem_wa     = i_reg[IDX_W-1:0];
                i_next     = i_reg + CNT_W'(1);
                state_next = ST_SHL_RD;
            end

            // Spread the list upward from the end, adding value after each match.
            ST_INS_RD: begin
                rd_addr = IDX_W'(i_reg - CNT_W'(1));
                if (i_reg == '0) begin
                    cnt_next   = cnt_reg + m_reg;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_INS_EX;
                end
            end

            ST_INS_EX: begin
                rd_addr  = IDX_W'(i_reg - CNT_W'(1));
                mem_we   = 1'b1;
                mem_wa   = IDX_W'(dst_reg - CNT_W'(1));
                dst_next = dst_reg - CNT_W'(1);
                if (!flag_reg && hit) begin
                    mem_wd    = val_reg;
                    flag_next = 1'b1;
                end else begin
                    flag_next  = 1'b0;
                    i_next     = i_reg - CNT_W'(1);
                    state_next = ST_INS_RD;
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    load       = 1'b1;
                    ld_st      = res_st_reg;
                    ld_pos     = res_pos_reg;
                    ld_el      = res_el_reg;
                    ld_last    = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            o_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (load) begin
                o_valid_reg <= 1'b1;
            end else if (m_tready) begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // Working and result payload registers.
    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        val_reg      <= val_next;
        key_reg      <= key_next;
        i_reg        <= i_next;
        tgt_reg      <= tgt_next;
        f_reg        <= f_next;
        m_reg        <= m_next;
        dst_reg      <= dst_next;
        pend_pos_reg <= pend_pos_next;
        found_reg    <= found_next;
        pend_reg     <= pend_next;
        flag_reg     <= flag_next;
        res_st_reg   <= res_st_next;
        res_pos_reg  <= res_pos_next;
        res_el_reg   <= res_el_next;
        if (load) begin
            o_st_reg   <= ld_st;
            o_pos_reg  <= POS_W'(ld_pos);
            o_el_reg   <= ld_el;
            o_len_reg  <= POS_W'(cnt_reg);
            o_last_reg <= ld_last;
        end
    end

    // List memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {2'b00, o_len_reg, o_el_reg, o_pos_reg};
    assign m_tuser  = o_st_reg;
    assign m_tlast  = o_last_reg;

    // The element count never passes the capacity.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    // A final result taken from the emit state leaves the engine idle with a last item.
    a_emit_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free) |=>
        (state_reg == ST_IDLE && o_valid_reg && o_last_reg))
        else $error("emit did not produce a final result");

    // Completing a gap fill grows the list by exactly one.
    a_ins_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHR_RD && i_reg == tgt_reg) |=>
        (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("insert did not grow the list by one");

endmodule

/* rtl/core/bounded_ordered_list_engine.sv */
// Bounded ordered list engine: a front queue feeding a list sequencer.
// Errors found at intake and unused commands go straight to the result; inserts
// and deletes move each shifted entry in turn; searches read the entries in turn.
// Throughput: one command at a time in the back end, bounded by the list
// memory (one read and one write per cycle); the front queue holds two.
// Reset empties the list at once; no clearing pass runs over the memory.
module bounded_ordered_list_engine (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata: value [31:0], key [63:32], position [70:64], zero fill [71]
    input  logic [71:0]  s_tdata,
    // s_tuser: action [3:0]
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: found_position [6:0], element [38:7], length [45:39], zero fill [47:46]
    output logic [47:0]  m_tdata,
    // m_tuser: status [2:0]
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);
    import bole_pkg::*;

    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    // Command intake and queue.
    bole_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    // List execution and result output.
    bole_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* tb/tb_bounded_ordered_list_engine.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the bounded ordered list engine.
// Depends on bole_pkg and bounded_ordered_list_engine with its bole_front and bole_back.
module tb_bounded_ordered_list_engine;
    import bole_pkg::*;

    // One result item as seen on the result channel.
    typedef struct {
        logic [2:0]  status;
        logic [6:0]  fpos;
        logic [31:0] element;
        logic [6:0]  length;
        logic        last;
    } list_result_t;

    // Predicts list results and compares them with the block's output.
    class list_scoreboard;
        logic [31:0]  words[CAPACITY];
        int           count;
        list_result_t pending[$];
        int           mismatches;

        function void put(logic [2:0] st, int p, logic [31:0] el, bit lst);
            list_result_t r;
            r.status = st; r.fpos = p[6:0]; r.element = el;
            r.length = count[6:0]; r.last = lst;
            pending.push_back(r);
        endfunction

        function void shift_in(int idx, logic [31:0] v);
            for (int i = count; i > idx; i--) words[i] = words[i-1];
            words[idx] = v;
            count++;
        endfunction

        function logic [31:0] shift_out(int idx);
            logic [31:0] v;
            v = words[idx];
            for (int i = idx; i + 1 < count; i++) words[i] = words[i+1];
            count--;
            return v;
        endfunction

        function int locate(logic [31:0] k);
            for (int i = 0; i < count; i++) if (words[i] == k) return i;
            return -1;
        endfunction

        // Works out the results of one accepted command.
        function void note_command(logic [3:0] act, logic [31:0] val,
                                   logic [31:0] k, logic [6:0] p_in);
            int n, f, m, p, dst, hits;
            logic [31:0] tmp[CAPACITY];
            n = count;
            p = p_in;
            if (act >= ACT_FIND && act <= ACT_READ && n == 0) begin
                put(STAT_EMPTY, 0, 0, 1);
                return;
            end
            case (act)
                ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS: begin
                    if (n >= CAPACITY) begin
                        put(STAT_FULL, 0, 0, 1);
                        return;
                    end
                    if (act == ACT_INS_HEAD) p = 1;
                    else if (act == ACT_INS_TAIL) p = n + 1;
                    else if (p == 0 || p > n + 1) begin
                        put(STAT_RANGE, 0, 0, 1);
                        return;
                    end
                    shift_in(p - 1, val);
                    put(STAT_OK, p, val, 1);
                end
                ACT_FIND: begin
                    f = locate(k);
                    if (f < 0) put(STAT_NOT_FOUND, 0, 0, 1);
                    else put(STAT_OK, f + 1, k, 1);
                end
                ACT_FIND_ALL: begin
                    hits = 0;
                    for (int i = 0; i < n && hits < 64; i++)
                        if (words[i] == k) begin
                            put(STAT_OK, i + 1, k, 0);
                            hits++;
                        end
                    if (hits == 0) put(STAT_NOT_FOUND, 0, 0, 1);
                    else pending[pending.size()-1].last = 1;
                end
                ACT_INS_AFTER: begin
                    if (n >= CAPACITY) begin
                        put(STAT_FULL, 0, 0, 1);
                        return;
                    end
                    f = locate(k);
                    if (f < 0) put(STAT_NOT_FOUND, 0, 0, 1);
                    else begin
                        shift_in(f + 1, val);
                        put(STAT_OK, f + 2, k, 1);
                    end
                end
                ACT_INS_AFTALL: begin
                    m = 0;
                    for (int i = 0; i < n; i++) if (words[i] == k) m++;
                    if (m == 0) put(STAT_NOT_FOUND, 0, 0, 1);
                    else if (n + m > CAPACITY) put(STAT_FULL, 0, 0, 1);
                    else begin
                        f = locate(k);
                        dst = 0;
                        for (int i = 0; i < n; i++) begin
                            tmp[dst++] = words[i];
                            if (words[i] == k) tmp[dst++] = val;
                        end
                        for (int i = 0; i < dst; i++) words[i] = tmp[i];
                        count = dst;
                        put(STAT_OK, f + 2, k, 1);
                    end
                end
                ACT_DEL_HEAD, ACT_DEL_TAIL, ACT_DEL_POS: begin
                    if (act == ACT_DEL_HEAD) p = 1;
                    else if (act == ACT_DEL_TAIL) p = n;
                    else if (p == 0 || p > n) begin
                        put(STAT_RANGE, 0, 0, 1);
                        return;
                    end
                    val = shift_out(p - 1);
                    put(STAT_OK, p, val, 1);
                end
                ACT_DEL_KEY: begin
                    f = locate(k);
                    if (f < 0) put(STAT_NOT_FOUND, 0, 0, 1);
                    else begin
                        void'(shift_out(f));
                        put(STAT_OK, f + 1, k, 1);
                    end
                end
                ACT_DEL_ALL: begin
                    f = locate(k);
                    if (f < 0) put(STAT_NOT_FOUND, 0, 0, 1);
                    else begin
                        m = 0;
                        for (int i = 0; i < n; i++)
                            if (words[i] != k) words[m++] = words[i];
                        count = m;
                        put(STAT_OK, f + 1, k, 1);
                    end
                end
                ACT_READ: begin
                    for (int i = 0; i < n && i < 64; i++)
                        put(STAT_OK, i + 1, words[i], 0);
                    pending[pending.size()-1].last = 1;
                end
                default: put(STAT_OK, 0, 0, 1);
            endcase
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_result(list_result_t got);
            list_result_t w;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: st=%0d pos=%0d el=%h len=%0d last=%0d",
                             got.status, got.fpos, got.element, got.length, got.last);
                return;
            end
            w = pending.pop_front();
            if (got.status !== w.status || got.fpos !== w.fpos ||
                got.element !== w.element || got.length !== w.length ||
                got.last !== w.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: want st=%0d pos=%0d el=%h len=%0d last=%0d, %s",
                             w.status, w.fpos, w.element, w.length, w.last,
                             $sformatf("got st=%0d pos=%0d el=%h len=%0d last=%0d",
                             got.status, got.fpos, got.element, got.length, got.last));
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    list_scoreboard board;
    bit   quiet_phase = 0;
    bit   timed_out = 0;
    int   idle_cycles = 0;
    logic [31:0] pool[8];

    bounded_ordered_list_engine u_top (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // Receiver with random stall bursts.
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                m_tready <= 0;
                gap = $urandom_range(1, 9);
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1;
        end
    end

    // Result monitor and stall watchdog.
    always @(posedge aclk) begin
        list_result_t got;
        if (aresetn) begin
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                got.status = m_tuser; got.fpos = m_tdata[6:0];
                got.element = m_tdata[38:7]; got.length = m_tdata[45:39];
                got.last = m_tlast;
                board.check_result(got);
            end
            if (idle_cycles > 20000) timed_out = 1;
        end
    end

    // Sends one command and waits for its acceptance; tvalid stays up for a
    // back-to-back follower and drops only during an idle gap.
    task automatic send_command(logic [3:0] act, logic [31:0] val, logic [31:0] k,
                                logic [6:0] p);
        int gap;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, p, k, val};
        do @(posedge aclk); while (!s_tready);
        board.note_command(act, val, k, p);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        @(negedge aclk);
        while (board.pending.size() != 0 && !timed_out) @(negedge aclk);
    endtask

    // Picks a key from a small pool so matches are common.
    function automatic logic [31:0] pick_word();
        if ($urandom_range(0, 9) < 8) return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    task automatic random_command(int fill_bias);
        logic [3:0] act;
        int r;
        r = $urandom_range(0, 99);
        if (r < fill_bias) act = 4'($urandom_range(ACT_INS_HEAD, ACT_INS_POS));
        else if (r < 98) act = 4'($urandom_range(ACT_FIND, ACT_READ));
        else act = 4'($urandom_range(13, 15));
        send_command(act, pick_word(), pick_word(),
                     7'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                 : $urandom_range(0, board.count + 1)));
    endtask

    initial begin
        board = new();
        pool[0] = 32'h0000_0000; pool[1] = 32'hFFFF_FFFF;
        pool[2] = 32'h7FFF_FFFF; pool[3] = 32'h8000_0000;
        for (int i = 4; i < 8; i++) pool[i] = $urandom;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        fork
            begin
                // Directed: empty list cases, extremes, every action.
                send_command(ACT_READ, 0, 0, 0);
                send_command(ACT_DEL_HEAD, 0, 0, 0);
                send_command(ACT_FIND, 0, 5, 0);
                send_command(ACT_INS_POS, 32'h1, 0, 7'd0);
                send_command(ACT_INS_POS, 32'h1, 0, 7'd2);
                send_command(ACT_INS_HEAD, 32'h7FFF_FFFF, 0, 0);
                send_command(ACT_INS_TAIL, 32'h8000_0000, 0, 0);
                send_command(ACT_INS_POS, 32'hFFFF_FFFF, 0, 7'd3);
                send_command(ACT_INS_AFTER, 32'h5, 32'h7FFF_FFFF, 0);
                send_command(ACT_INS_AFTALL, 32'h7FFF_FFFF, 32'h5, 0);
                send_command(ACT_INS_AFTALL, 32'h9, 32'h1234, 0);
                send_command(ACT_FIND_ALL, 0, 32'h7FFF_FFFF, 0);
                send_command(ACT_FIND, 0, 32'h8000_0000, 0);
                send_command(ACT_DEL_POS, 0, 0, 7'd127);
                send_command(ACT_DEL_POS, 0, 0, 7'd2);
                send_command(ACT_DEL_KEY, 0, 32'hFFFF_FFFF, 0);
                send_command(ACT_DEL_ALL, 0, 32'h7FFF_FFFF, 0);
                send_command(ACT_DEL_TAIL, 0, 0, 0);
                send_command(4'd15, 0, 0, 0);
                send_command(ACT_READ, 0, 0, 0);
                // Fill to capacity, then hit the full cases and long runs.
                while (board.count < CAPACITY)
                    send_command(ACT_INS_TAIL, pool[$urandom_range(0, 1)], 0, 0);
                send_command(ACT_INS_HEAD, 1, 0, 0);
                send_command(ACT_INS_AFTER, 1, pool[0], 0);
                send_command(ACT_INS_AFTALL, 1, pool[1], 0);
                send_command(ACT_READ, 0, 0, 0);
                send_command(ACT_FIND_ALL, 0, pool[0], 0);
                wait_drained();
                // Random: phases that grow, churn and shrink the list.
                for (int i = 0; i < 400 && !timed_out; i++) begin
                    if (i == 340) begin
                        wait_drained();
                        quiet_phase = 1;
                    end
                    random_command(board.count < 8 ? 60 :
                                   (((i / 60) % 2) ? 15 : 45));
                end
            end
            begin
                wait (timed_out);
            end
        join_any
        disable fork;
        s_tvalid <= 0;

        while (board.pending.size() != 0 && !timed_out) @(negedge aclk);
        repeat (300) @(negedge aclk);
        if (timed_out) begin
            $display("CHECK FAILED");
        end else if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
